### src/tbwp_pkg.sv
package tbwp_pkg;

   // video memory: bytes, stored as 16-bit words so one read yields a tile row pair
   localparam int VRAM_BYTES = 8192;
   localparam int VRAM_AW    = $clog2(VRAM_BYTES);
   localparam int WORD_COUNT = VRAM_BYTES / 2;
   localparam int WORD_AW    = $clog2(WORD_COUNT);

   // work queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;
   localparam logic [2:0] REG_DISPLAY_CONTROL = 3'd0;
   localparam logic [2:0] REG_SCROLL_X        = 3'd1;
   localparam logic [2:0] REG_SCROLL_Y        = 3'd2;
   localparam logic [2:0] REG_WINDOW_TOP      = 3'd3;
   localparam logic [2:0] REG_BG_PALETTE      = 3'd4;
   localparam logic [7:0] BG_PALETTE_RESET    = 8'd27;

   // request codes on req_type
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_RENDER = 1'b1;

   // display_control bits
   localparam int CTRL_WIN_MAP   = 6;
   localparam int CTRL_WIN_ON    = 5;
   localparam int CTRL_TILE_MODE = 4;
   localparam int CTRL_BG_MAP    = 3;
   localparam int CTRL_BG_ON     = 0;

   localparam logic [7:0] WINDOW_LINES = 8'd144;
   // tile maps start at offset 0x1800: top two address bits set
   localparam logic [1:0] MAP_BASE_HI  = 2'b11;

   // job kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_RENDER = 2'd1;
   localparam logic [1:0] KIND_BLANK  = 2'd2;

   typedef struct packed {
      logic [7:0] display_control;
      logic [7:0] scroll_x;
      logic [7:0] scroll_y;
      logic [7:0] window_top;
      logic [7:0] bg_palette;
   } cfg_type;

   // addr is the write offset for writes, the tile map byte address for renders
   typedef struct packed {
      logic [1:0]         kind;
      logic [VRAM_AW-1:0] addr;
      logic [7:0]         data;
      logic [2:0]         cy_lo;
      logic [2:0]         cx_lo;
   } job_type;

   function automatic logic [23:0] shade_rgb(input logic [1:0] shade);
      logic [23:0] rgb;
      case (shade)
         2'd0:    rgb = 24'hFFFFFF;
         2'd1:    rgb = 24'hC0C0C0;
         2'd2:    rgb = 24'h808080;
         default: rgb = 24'h000000;
      endcase
      return rgb;
   endfunction

endpackage

### src/tbwp_csr.sv
module tbwp_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tbwp_pkg::CSR_AW-1:0]  paddr,
   input  logic [tbwp_pkg::CSR_DW-1:0]  pwdata,
   output logic [tbwp_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready,
   output tbwp_pkg::cfg_type            cfg
);

   tbwp_pkg::cfg_type cfg_ff;
   logic [2:0]        reg_idx;
   logic              wr_en;
   logic [7:0]        rd_byte;

   assign reg_idx = paddr[4:2];
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_control <= '0;
         cfg_ff.scroll_x        <= '0;
         cfg_ff.scroll_y        <= '0;
         cfg_ff.window_top      <= '0;
         cfg_ff.bg_palette      <= tbwp_pkg::BG_PALETTE_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            tbwp_pkg::REG_DISPLAY_CONTROL: cfg_ff.display_control <= pwdata[7:0];
            tbwp_pkg::REG_SCROLL_X:        cfg_ff.scroll_x        <= pwdata[7:0];
            tbwp_pkg::REG_SCROLL_Y:        cfg_ff.scroll_y        <= pwdata[7:0];
            tbwp_pkg::REG_WINDOW_TOP:      cfg_ff.window_top      <= pwdata[7:0];
            tbwp_pkg::REG_BG_PALETTE:      cfg_ff.bg_palette      <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tbwp_pkg::REG_DISPLAY_CONTROL: rd_byte = cfg_ff.display_control;
         tbwp_pkg::REG_SCROLL_X:        rd_byte = cfg_ff.scroll_x;
         tbwp_pkg::REG_SCROLL_Y:        rd_byte = cfg_ff.scroll_y;
         tbwp_pkg::REG_WINDOW_TOP:      rd_byte = cfg_ff.window_top;
         tbwp_pkg::REG_BG_PALETTE:      rd_byte = cfg_ff.bg_palette;
         default:                       rd_byte = '0;
      endcase
   end

   assign prdata = {{(tbwp_pkg::CSR_DW - 8){1'b0}}, rd_byte};
   assign cfg    = cfg_ff;

endmodule

### src/tbwp_front.sv
module tbwp_front (
   input  tbwp_pkg::cfg_type                cfg,
   input  logic                             start,
   input  logic                             queue_full,
   input  logic                             req_type,
   input  logic [tbwp_pkg::VRAM_AW-1:0]     req_vram_offset,
   input  logic [7:0]                       req_vram_byte,
   input  logic [7:0]                       req_screen_line,
   input  logic [7:0]                       req_screen_column,
   output logic                             busy,
   output logic                             push,
   output tbwp_pkg::job_type                job
);

   logic [7:0] line_rel;
   logic       in_window;
   logic [7:0] cx;
   logic [7:0] cy;
   logic       map_sel;

   assign busy = queue_full;
   assign push = start && !queue_full;

   assign line_rel  = req_screen_line - cfg.window_top;
   assign in_window = cfg.display_control[tbwp_pkg::CTRL_WIN_ON]
                      && (req_screen_line >= cfg.window_top)
                      && (line_rel < tbwp_pkg::WINDOW_LINES);

   always_comb begin
      if (in_window) begin
         cx      = req_screen_column;
         cy      = line_rel;
         map_sel = cfg.display_control[tbwp_pkg::CTRL_WIN_MAP];
      end else begin
         // background wraps at 256
         cx      = req_screen_column + cfg.scroll_x;
         cy      = req_screen_line + cfg.scroll_y;
         map_sel = cfg.display_control[tbwp_pkg::CTRL_BG_MAP];
      end
   end

   always_comb begin
      job.data  = req_vram_byte;
      job.cy_lo = cy[2:0];
      job.cx_lo = cx[2:0];
      if (req_type == tbwp_pkg::REQ_WRITE) begin
         job.kind = tbwp_pkg::KIND_WRITE;
         job.addr = req_vram_offset;
      end else begin
         job.addr = {tbwp_pkg::MAP_BASE_HI, map_sel, cy[7:3], cx[7:3]};
         if (in_window || cfg.display_control[tbwp_pkg::CTRL_BG_ON]) begin
            job.kind = tbwp_pkg::KIND_RENDER;
         end else begin
            job.kind = tbwp_pkg::KIND_BLANK;
         end
      end
   end

endmodule

### src/tbwp_queue.sv
module tbwp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tbwp_pkg::job_type  push_job,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output tbwp_pkg::job_type  head_job
);

   tbwp_pkg::job_type           slot_ff [tbwp_pkg::QUEUE_DEPTH];
   logic [tbwp_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [tbwp_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [tbwp_pkg::QCNT_W-1:0] count_ff;
   logic [tbwp_pkg::QCNT_W-1:0] count_in;
   logic                        do_push;
   logic                        do_pop;

   function automatic logic [tbwp_pkg::QPTR_W-1:0] next_ptr(
      input logic [tbwp_pkg::QPTR_W-1:0] ptr);
      logic [tbwp_pkg::QPTR_W-1:0] nxt;
      if (ptr == tbwp_pkg::QPTR_W'(tbwp_pkg::QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   assign full       = (count_ff == tbwp_pkg::QCNT_W'(tbwp_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### src/tbwp_back.sv
module tbwp_back (
   input  logic               clock,
   input  logic               reset,
   input  tbwp_pkg::cfg_type  cfg,
   input  logic               head_valid,
   input  tbwp_pkg::job_type  head_job,
   output logic               pop,
   output logic               rsp_valid,
   output logic [1:0]         rsp_colour_index,
   output logic [1:0]         rsp_shade,
   output logic [23:0]        rsp_pixel_rgb
);

   // two byte lanes per word: lane 0 even offset, lane 1 odd offset
   logic [1:0][7:0] vram_mem [tbwp_pkg::WORD_COUNT];

   logic                         mem_we;
   logic [tbwp_pkg::WORD_AW-1:0] tile_waddr;
   logic [7:0]                   tile_num;

   // stage 1: map word read
   logic            s1_valid_ff;
   logic [1:0]      s1_kind_ff;
   logic            s1_lane_ff;
   logic [2:0]      s1_cy_ff;
   logic [2:0]      s1_cx_ff;
   logic [1:0][7:0] map_word_ff;

   // stage 2: tile row word read
   logic            s2_valid_ff;
   logic [1:0]      s2_kind_ff;
   logic [2:0]      s2_cx_ff;
   logic [1:0][7:0] tile_word_ff;

   logic [2:0]  bit_sel;
   logic [1:0]  colour;
   logic [1:0]  shade;
   logic [1:0]  colour_in;
   logic [1:0]  shade_in;
   logic [23:0] rgb_in;
   logic        rsp_valid_ff;
   logic [1:0]  colour_ff;
   logic [1:0]  shade_ff;
   logic [23:0] rgb_ff;

   // the back end never stalls
   assign pop    = head_valid;
   assign mem_we = head_valid && (head_job.kind == tbwp_pkg::KIND_WRITE);

   assign tile_num   = s1_lane_ff ? map_word_ff[1] : map_word_ff[0];
   // signed mode: 0x1000 + sext(tile) * 16 flips the top bit
   assign tile_waddr = {cfg.display_control[tbwp_pkg::CTRL_TILE_MODE] ? 1'b0 : ~tile_num[7],
                        tile_num, s1_cy_ff};

   // a write in stage 0 and a tile read of an older render in stage 1 on the
   // same edge: the read sees the old contents, which keeps item order
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vram_mem[head_job.addr[tbwp_pkg::VRAM_AW-1:1]][head_job.addr[0]] <= head_job.data;
      end
      map_word_ff  <= vram_mem[head_job.addr[tbwp_pkg::VRAM_AW-1:1]];
      tile_word_ff <= vram_mem[tile_waddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= head_job.kind;
      s1_lane_ff <= head_job.addr[0];
      s1_cy_ff   <= head_job.cy_lo;
      s1_cx_ff   <= head_job.cx_lo;
      s2_kind_ff <= s1_kind_ff;
      s2_cx_ff   <= s1_cx_ff;
      colour_ff  <= colour_in;
      shade_ff   <= shade_in;
      rgb_ff     <= rgb_in;
   end

   // leftmost pixel is bit 7
   assign bit_sel = ~s2_cx_ff;
   assign colour  = {tile_word_ff[1][bit_sel], tile_word_ff[0][bit_sel]};
   assign shade   = cfg.bg_palette[{colour, 1'b0} +: 2];

   always_comb begin
      unique case (s2_kind_ff)
         tbwp_pkg::KIND_RENDER: begin
            colour_in = colour;
            shade_in  = shade;
            rgb_in    = tbwp_pkg::shade_rgb(shade);
         end
         tbwp_pkg::KIND_BLANK: begin
            colour_in = '0;
            shade_in  = '0;
            rgb_in    = tbwp_pkg::shade_rgb(2'd0);
         end
         default: begin
            colour_in = '0;
            shade_in  = '0;
            rgb_in    = '0;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_colour_index = colour_ff;
   assign rsp_shade        = shade_ff;
   assign rsp_pixel_rgb    = rgb_ff;

endmodule

### src/tile_background_window_pixel.sv
// Background/window pixel renderer with an 8 KiB video memory.
//
// Request channel: an item is taken on a rising edge with start high and busy
// low. req_type 0 stores req_vram_byte at req_vram_offset; req_type 1 renders
// the pixel at req_screen_line / req_screen_column.
// Result channel: every item, write or render, produces exactly one result,
// shown for one cycle with rsp_valid high. Writes return all-zero fields.
// Path: an accepted item passes the queue, the map read, the tile row read
// and the output register, in that order, before its result is shown.
// Throughput: one item per clock. The back end drains the two-entry queue
// every cycle, so busy stays low; the dual-read video memory (map word and
// tile row word in the same cycle, one byte write) sets that rate.
// The result side cannot stall; results must be taken as they appear.
// Configuration: APB registers at 0x00 display_control, 0x04 scroll_x,
// 0x08 scroll_y, 0x0C window_top, 0x10 bg_palette; write them only while idle.
// Reset clears the pipeline and the registers (bg_palette to 0x1B). Video
// memory is not cleared; render only from bytes that were written.
module tile_background_window_pixel (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_type,
   input  logic [tbwp_pkg::VRAM_AW-1:0] req_vram_offset,
   input  logic [7:0]                   req_vram_byte,
   input  logic [7:0]                   req_screen_line,
   input  logic [7:0]                   req_screen_column,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_colour_index,
   output logic [1:0]                   rsp_shade,
   output logic [23:0]                  rsp_pixel_rgb,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tbwp_pkg::CSR_AW-1:0]  paddr,
   input  logic [tbwp_pkg::CSR_DW-1:0]  pwdata,
   output logic [tbwp_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);

   tbwp_pkg::cfg_type cfg;
   tbwp_pkg::job_type push_job;
   tbwp_pkg::job_type head_job;
   logic              push;
   logic              pop;
   logic              queue_full;
   logic              head_valid;

   tbwp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tbwp_front u_front (
      .cfg               (cfg),
      .start             (start),
      .queue_full        (queue_full),
      .req_type          (req_type),
      .req_vram_offset   (req_vram_offset),
      .req_vram_byte     (req_vram_byte),
      .req_screen_line   (req_screen_line),
      .req_screen_column (req_screen_column),
      .busy              (busy),
      .push              (push),
      .job               (push_job)
   );

   tbwp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tbwp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head_valid       (head_valid),
      .head_job         (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_colour_index (rsp_colour_index),
      .rsp_shade        (rsp_shade),
      .rsp_pixel_rgb    (rsp_pixel_rgb)
   );

endmodule

### src/tbwp_checker.sv
module tbwp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_type,
   input logic                         rsp_valid,
   input logic [1:0]                   rsp_colour_index,
   input logic [1:0]                   rsp_shade,
   input logic [23:0]                  rsp_pixel_rgb,
   input logic                         psel,
   input logic                         penable,
   input logic                         pwrite,
   input logic [tbwp_pkg::CSR_AW-1:0]  paddr,
   input logic [tbwp_pkg::CSR_DW-1:0]  pwdata,
   input logic [tbwp_pkg::CSR_DW-1:0]  prdata,
   input logic                         pready
);

   logic req_xfer;
   logic csr_xfer;

   assign req_xfer = start && !busy;
   assign csr_xfer = psel && penable && pwrite && pready;

   // every accepted item is followed by its result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> ##4 rsp_valid)
      else $error("missing result after request transfer");

   // no result without an earlier accepted item
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_xfer, 4))
      else $error("result without matching request transfer");

   // writes answer all-zero
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_type, 4) == tbwp_pkg::REQ_WRITE |->
         rsp_colour_index == 2'd0 && rsp_shade == 2'd0 && rsp_pixel_rgb == 24'd0)
      else $error("write transfer returned nonzero result");

   // rendered pixels carry the rgb of their shade
   a_render_rgb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_type, 4) == tbwp_pkg::REQ_RENDER |->
         rsp_pixel_rgb == tbwp_pkg::shade_rgb(rsp_shade))
      else $error("pixel rgb does not match shade");

   // display_control reads back what was written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_xfer && paddr[4:2] == tbwp_pkg::REG_DISPLAY_CONTROL |=>
         paddr[4:2] != tbwp_pkg::REG_DISPLAY_CONTROL || prdata[7:0] == $past(pwdata[7:0]))
      else $error("display_control readback mismatch");

endmodule

bind tile_background_window_pixel tbwp_checker u_tbwp_checker (.*);
